[design/bist_pkg.sv]
// Package for the bounded integer set table: field widths, request and
// status codes, and the default store capacity.
// Depends on nothing; imported by the top level.
`timescale 1ns / 1ps

package bist_pkg;

  // Default number of member slots in the store.
  localparam int unsigned CapacityDef = 128;

  // Fixed widths of the transfer fields.
  localparam int unsigned DataW   = 32;
  localparam int unsigned ActW    = 2;
  localparam int unsigned StatW   = 2;
  localparam int unsigned PosW    = 7;
  localparam int unsigned MCountW = 8;

  // Request codes; the unused code is served as a lookup.
  typedef enum logic [ActW-1:0] {
    ACT_INSERT = 2'd0,
    ACT_REMOVE = 2'd1,
    ACT_LOOKUP = 2'd2,
    ACT_SPARE  = 2'd3
  } action_e;

  // Result status codes.
  typedef enum logic [StatW-1:0] {
    ST_OK      = 2'd0,
    ST_PRESENT = 2'd1,
    ST_FULL    = 2'd2,
    ST_MISSING = 2'd3
  } status_e;

  // Sequencer states, one-hot.
  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_SCAN   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_MOVE   = 5'b01000,
    S_DONE   = 5'b10000
  } state_e;

endpackage

[design/bist_ram.sv]
// Generic simple dual-port RAM: one write port and one read port with
// registered read data. Depends on nothing.
`timescale 1ns / 1ps

module bist_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[design/bounded_integer_set_table.sv]
// Top level of the bounded integer set table: request sequencer, scan
// logic and result register. Depends on bist_pkg and bist_ram.
`timescale 1ns / 1ps

// Usage
// The input channel (in_valid_i / in_ready_o) carries one request: an
// action (insert, remove or look up) and a signed 32-bit value. The output
// channel (out_valid_o / out_ready_i) returns exactly one result per
// request: status, slot position, member count, empty flag, and the
// largest and smallest members (-1 and 0 when the set is empty).
// A request passes through the scan, a decision step and, for a remove
// that succeeds, a move of the last member into the freed slot, and then
// waits until the output register is free to take its result; only then
// does the sequencer return to idle and take a new request. The scan
// reads every stored member through the single read port of the store,
// one per cycle, finding the value and updating the running maximum and
// minimum as it goes. One request is in flight at a time: in_ready_o is
// high only while the sequencer is idle.
// Reset empties the set at once; the store itself is not cleared, as only
// slots below the count are ever read. When the receiver stalls, the
// result waits in the output register; a following request may be taken
// meanwhile, and its result waits in the sequencer until the register
// frees.

module bounded_integer_set_table
  import bist_pkg::*;
#(
  parameter int unsigned CAPACITY = CapacityDef
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [ActW-1:0]           action_i,
  input  logic signed [DataW-1:0]   value_i,
  output logic                      out_valid_o,
  input  logic                      out_ready_i,
  output logic [StatW-1:0]          status_o,
  output logic [PosW-1:0]           position_o,
  output logic [MCountW-1:0]        member_count_o,
  output logic                      is_empty_o,
  output logic signed [DataW-1:0]   largest_o,
  output logic signed [DataW-1:0]   smallest_o
);

  localparam int unsigned IdxW = $clog2(CAPACITY);
  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [CntW-1:0] CntFull = CntW'(CAPACITY);

  state_e state_q, state_d;

  logic [CntW-1:0]         cnt_q, cnt_d;
  logic [ActW-1:0]         act_q, act_d;
  logic signed [DataW-1:0] val_q, val_d;

  // Scan pipeline: read address, read-data valid and its slot index.
  logic [CntW-1:0] addr_q, addr_d;
  logic            rv_q, rv_d;
  logic [IdxW-1:0] cidx_q, cidx_d;

  // Search result and running extremes of the post-request members.
  logic                    found_q, found_d;
  logic [IdxW-1:0]         slot_q, slot_d;
  logic                    acc_v_q, acc_v_d;
  logic signed [DataW-1:0] max_q, max_d;
  logic signed [DataW-1:0] min_q, min_d;

  // Staged result fields.
  status_e         res_st_q, res_st_d;
  logic [IdxW-1:0] res_pos_q, res_pos_d;

  // Output register.
  logic                    ovalid_q, ovalid_d;
  logic [StatW-1:0]        ostat_q, ostat_d;
  logic [PosW-1:0]         opos_q, opos_d;
  logic [MCountW-1:0]      ocnt_q, ocnt_d;
  logic                    oempty_q, oempty_d;
  logic signed [DataW-1:0] olarge_q, olarge_d;
  logic signed [DataW-1:0] osmall_q, osmall_d;

  // Store ports.
  logic             we;
  logic [IdxW-1:0]  waddr;
  logic [DataW-1:0] wdata;
  logic             re;
  logic [IdxW-1:0]  raddr;
  logic [DataW-1:0] rdata;

  logic signed [DataW-1:0] rdata_s;
  logic [CntW-1:0]         cnt_m1;
  logic                    incl_v;
  logic                    out_free;

  assign rdata_s  = $signed(rdata);
  assign cnt_m1   = cnt_q - CntW'(1);
  assign out_free = !ovalid_q || out_ready_i;

  bist_ram #(
    .Width (DataW),
    .Depth (CAPACITY)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  // Sequencer and datapath.
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    act_d     = act_q;
    val_d     = val_q;
    addr_d    = addr_q;
    rv_d      = 1'b0;
    cidx_d    = cidx_q;
    found_d   = found_q;
    slot_d    = slot_q;
    acc_v_d   = acc_v_q;
    max_d     = max_q;
    min_d     = min_q;
    res_st_d  = res_st_q;
    res_pos_d = res_pos_q;
    ovalid_d  = ovalid_q && !out_ready_i;
    ostat_d   = ostat_q;
    opos_d    = opos_q;
    ocnt_d    = ocnt_q;
    oempty_d  = oempty_q;
    olarge_d  = olarge_q;
    osmall_d  = osmall_q;
    we        = 1'b0;
    waddr     = slot_q;
    wdata     = rdata;
    re        = 1'b0;
    raddr     = addr_q[IdxW-1:0];
    incl_v    = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d   = action_i;
          val_d   = value_i;
          addr_d  = '0;
          found_d = 1'b0;
          slot_d  = '0;
          acc_v_d = 1'b0;
          state_d = S_SCAN;
        end
      end

      S_SCAN: begin
        // Issue the next read while members remain.
        if (addr_q != cnt_q) begin
          re     = 1'b1;
          rv_d   = 1'b1;
          cidx_d = addr_q[IdxW-1:0];
          addr_d = addr_q + CntW'(1);
        end
        // Check the member read in the previous cycle.
        if (rv_q) begin
          if (rdata_s == val_q) begin
            found_d = 1'b1;
            slot_d  = cidx_q;
          end else begin
            acc_v_d = 1'b1;
            if (!acc_v_q || rdata_s > max_q) begin
              max_d = rdata_s;
            end
            if (!acc_v_q || rdata_s < min_q) begin
              min_d = rdata_s;
            end
          end
        end
        if (addr_q == cnt_q && !rv_q) begin
          state_d = S_DECIDE;
        end
      end

      S_DECIDE: begin
        res_st_d  = ST_MISSING;
        res_pos_d = '0;
        state_d   = S_DONE;
        case (act_q)
          ACT_INSERT: begin
            if (found_q) begin
              res_st_d  = ST_PRESENT;
              res_pos_d = slot_q;
              incl_v    = 1'b1;
            end else if (cnt_q == CntFull) begin
              res_st_d = ST_FULL;
            end else begin
              we        = 1'b1;
              waddr     = cnt_q[IdxW-1:0];
              wdata     = val_q;
              res_pos_d = cnt_q[IdxW-1:0];
              res_st_d  = ST_OK;
              cnt_d     = cnt_q + CntW'(1);
              incl_v    = 1'b1;
            end
          end
          ACT_REMOVE: begin
            if (found_q) begin
              // Fetch the last member to fill the freed slot.
              re        = 1'b1;
              raddr     = cnt_m1[IdxW-1:0];
              cnt_d     = cnt_m1;
              res_st_d  = ST_OK;
              res_pos_d = slot_q;
              state_d   = S_MOVE;
            end
          end
          default: begin
            if (found_q) begin
              res_st_d  = ST_OK;
              res_pos_d = slot_q;
              incl_v    = 1'b1;
            end
          end
        endcase
        // Fold the request value into the extremes when it is a member.
        if (incl_v) begin
          acc_v_d = 1'b1;
          if (!acc_v_q || val_q > max_q) begin
            max_d = val_q;
          end
          if (!acc_v_q || val_q < min_q) begin
            min_d = val_q;
          end
        end
      end

      S_MOVE: begin
        we      = 1'b1;
        waddr   = slot_q;
        wdata   = rdata;
        state_d = S_DONE;
      end

      S_DONE: begin
        if (out_free) begin
          ovalid_d = 1'b1;
          ostat_d  = res_st_q;
          opos_d   = PosW'(res_pos_q);
          ocnt_d   = MCountW'(cnt_q);
          oempty_d = (cnt_q == '0);
          olarge_d = acc_v_q ? max_q : -32'sd1;
          osmall_d = acc_v_q ? min_q : 32'sd0;
          state_d  = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      cnt_q    <= '0;
      rv_q     <= 1'b0;
      ovalid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cnt_q    <= cnt_d;
      rv_q     <= rv_d;
      ovalid_q <= ovalid_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    act_q     <= act_d;
    val_q     <= val_d;
    addr_q    <= addr_d;
    cidx_q    <= cidx_d;
    found_q   <= found_d;
    slot_q    <= slot_d;
    acc_v_q   <= acc_v_d;
    max_q     <= max_d;
    min_q     <= min_d;
    res_st_q  <= res_st_d;
    res_pos_q <= res_pos_d;
    ostat_q   <= ostat_d;
    opos_q    <= opos_d;
    ocnt_q    <= ocnt_d;
    oempty_q  <= oempty_d;
    olarge_q  <= olarge_d;
    osmall_q  <= osmall_d;
  end

  assign in_ready_o     = (state_q == S_IDLE);
  assign out_valid_o    = ovalid_q;
  assign status_o       = ostat_q;
  assign position_o     = opos_q;
  assign member_count_o = ocnt_q;
  assign is_empty_o     = oempty_q;
  assign largest_o      = olarge_q;
  assign smallest_o     = osmall_q;

`ifndef ASSERT_OFF
  // The member count never exceeds the store capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni) cnt_q <= CntFull)
    else $error("member count above capacity");

  // The count changes only when a request is decided.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q != $past(cnt_q)) |-> ($past(state_q) == S_DECIDE))
    else $error("member count changed outside the decision step");

  // The scan address never runs past the member count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) |-> (addr_q <= cnt_q))
    else $error("scan address beyond member count");

  // A transfer in makes the block busy on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("request taken while busy");

  // A non-empty result has its largest member no smaller than its least.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !is_empty_o) |-> (largest_o >= smallest_o))
    else $error("largest member below smallest member");
`endif

endmodule
